### design/acr_pkg.sv
package acr_pkg;

  // Byte and window geometry
  localparam int BYTE_W   = 8;
  localparam int WIN_KEEP = 9;
  localparam int SEEN_W   = $clog2(WIN_KEEP + 1);

  // Frame header constants
  localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hB5;
  localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h62;
  localparam logic [BYTE_W-1:0] ACK_CLASS   = 8'h05;
  localparam logic [BYTE_W-1:0] ID_ACK      = 8'h01;
  localparam logic [BYTE_W-1:0] ID_NACK     = 8'h00;

  // Window positions, oldest byte at position 0
  localparam int POS_ID     = 3;
  localparam int POS_CLASS  = 6;
  localparam int POS_MSG_ID = 7;

  // Positions that take part in the frame compare
  localparam logic [WIN_KEEP-1:0] CARE_MASK = 9'b011000111;

  // Fixed compare keys; class and message id positions come from registers
  localparam logic [BYTE_W-1:0] FIXED_KEY [WIN_KEEP] = '{
    SYNC_FIRST, SYNC_SECOND, ACK_CLASS, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam logic [CFG_INDEX_W-1:0] CFG_CLASS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ID    = 1'd1;

  localparam logic [BYTE_W-1:0] CLASS_RESET = 8'h06;
  localparam logic [BYTE_W-1:0] ID_RESET    = 8'h00;

  // Verdict codes
  localparam int VERDICT_W = 2;
  localparam logic [VERDICT_W-1:0] VERDICT_ACK  = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_NACK = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_NONE = 2'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_BAD  = 2'd3;

endpackage

### design/acr_ifs.sv
interface acr_in_if;
  logic                        valid;
  logic                        ready;
  logic [acr_pkg::BYTE_W-1:0]  data_byte;
  logic                        last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface acr_out_if;
  logic                          valid;
  logic                          ready;
  logic [acr_pkg::VERDICT_W-1:0] verdict;

  modport source(output valid, output verdict, input ready);
  modport sink(input valid, input verdict, output ready);
endinterface

### design/acr_cell.sv
module acr_cell (
  input  logic                       clk,
  input  logic                       advance,
  input  logic [acr_pkg::BYTE_W-1:0] shift_in,
  input  logic [acr_pkg::BYTE_W-1:0] key,
  input  logic                       care,
  output logic [acr_pkg::BYTE_W-1:0] held,
  output logic                       hit
);

  // Take the neighbor's byte on every transfer
  always_ff @(posedge clk) begin
    if (advance) begin
      held <= shift_in;
    end
  end

  // Compare against this position's key, or pass when the position is ignored
  assign hit = !care || (held == key);

endmodule

### design/ack_response_scanner_top.sv
// Output: the verdict is registered into the output register, or the skid slot if stalled.
// Throughput: one byte per cycle while the skid slot is empty; the window is a nine-cell
// shift chain whose held bytes are compared in parallel, and input waits while skid is full.
// Two verdict slots (output register and skid) keep input ready while a verdict waits.
// Reset: synchronous, active high; clears byte count, decision and output slots, and
// loads expected class 6 and expected id 0. Window bytes are not reset.
module ack_response_scanner_top (
  input  logic                            clk,
  input  logic                            rst,
  acr_in_if.sink                          byte_stream,
  acr_out_if.source                       result,
  input  logic                            cfg_we,
  input  logic [acr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [acr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int WK = acr_pkg::WIN_KEEP;
  localparam int BW = acr_pkg::BYTE_W;

  logic [BW-1:0] expected_class;
  logic [BW-1:0] expected_id;

  logic [BW-1:0] cell_byte [WK];
  logic [BW-1:0] chain_in  [WK];
  logic [BW-1:0] cell_key  [WK];
  logic [WK-1:0] cell_hit;

  logic [acr_pkg::SEEN_W-1:0] bytes_seen;
  logic                       decided;
  logic                       decided_nack;
  logic                       decided_next;
  logic                       decided_nack_next;

  logic                            out_valid;
  logic [acr_pkg::VERDICT_W-1:0]   out_verdict;
  logic                            skid_valid;
  logic [acr_pkg::VERDICT_W-1:0]   skid_verdict;
  logic [acr_pkg::VERDICT_W-1:0]   new_verdict;

  logic in_xfer;
  logic last_xfer;
  logic out_free;
  logic examine_en;
  logic frame_hit;
  logic hit_ack;
  logic hit_nack;

  // Accept input whenever the skid slot is free
  assign byte_stream.ready = !skid_valid;
  assign in_xfer           = byte_stream.valid && byte_stream.ready;
  assign last_xfer         = in_xfer && byte_stream.last_byte;

  // Hold the expected class and message id
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_class <= acr_pkg::CLASS_RESET;
      expected_id    <= acr_pkg::ID_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        acr_pkg::CFG_CLASS: expected_class <= cfg_data;
        acr_pkg::CFG_ID:    expected_id    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Build the compare keys for each window position
  always_comb begin
    for (int i = 0; i < WK; i++) begin
      cell_key[i] = acr_pkg::FIXED_KEY[i];
    end
    cell_key[acr_pkg::POS_CLASS]  = expected_class;
    cell_key[acr_pkg::POS_MSG_ID] = expected_id;
  end

  // Window chain: the newest byte enters the top cell and moves toward position 0
  for (genvar i = 0; i < WK; i++) begin : g_cell
    if (i == WK - 1) begin : g_head
      assign chain_in[i] = byte_stream.data_byte;
    end else begin : g_link
      assign chain_in[i] = cell_byte[i+1];
    end

    acr_cell u_cell (
      .clk      (clk),
      .advance  (in_xfer),
      .shift_in (chain_in[i]),
      .key      (cell_key[i]),
      .care     (acr_pkg::CARE_MASK[i]),
      .held     (cell_byte[i]),
      .hit      (cell_hit[i])
    );
  end

  // Examine the held window as a further byte arrives, once nine bytes are held
  assign examine_en = !decided && (bytes_seen >= acr_pkg::SEEN_W'(WK));
  assign frame_hit  = examine_en && (&cell_hit);
  assign hit_ack    = frame_hit && (cell_byte[acr_pkg::POS_ID] == acr_pkg::ID_ACK);
  assign hit_nack   = frame_hit && (cell_byte[acr_pkg::POS_ID] == acr_pkg::ID_NACK);

  assign decided_next      = decided || hit_ack || hit_nack;
  assign decided_nack_next = decided ? decided_nack : hit_nack;

  always_comb begin
    if (!decided_next) begin
      new_verdict = acr_pkg::VERDICT_NONE;
    end else if (decided_nack_next) begin
      new_verdict = acr_pkg::VERDICT_NACK;
    end else begin
      new_verdict = acr_pkg::VERDICT_ACK;
    end
  end

  // Advance count and decision; clear both at the end of a stream.
  // Window bytes need no clear: a compare waits for nine fresh bytes.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen   <= '0;
      decided      <= 1'b0;
      decided_nack <= 1'b0;
    end else if (last_xfer) begin
      bytes_seen   <= '0;
      decided      <= 1'b0;
      decided_nack <= 1'b0;
    end else if (in_xfer) begin
      if (bytes_seen < acr_pkg::SEEN_W'(WK)) begin
        bytes_seen <= bytes_seen + 1'b1;
      end
      decided      <= decided_next;
      decided_nack <= decided_nack_next;
    end
  end

  // Output register with one skid slot behind it
  assign out_free = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= last_xfer;
      end
    end else if (last_xfer) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_verdict <= skid_valid ? skid_verdict : new_verdict;
    end else if (last_xfer) begin
      skid_verdict <= new_verdict;
    end
  end

  assign result.valid   = out_valid;
  assign result.verdict = out_verdict;

  // The skid slot only fills behind a waiting verdict
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot holds a verdict while the output slot is empty");

  // A delivered verdict is never the unused code
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_verdict != acr_pkg::VERDICT_BAD))
    else $error("unused verdict code presented");

  // The end of a stream clears count and decision
  a_stream_clear: assert property (@(posedge clk) disable iff (rst)
    last_xfer |=> (bytes_seen == '0) && !decided)
    else $error("stream state not cleared after final byte");

  // The end of a stream always produces a verdict
  a_verdict_follows: assert property (@(posedge clk) disable iff (rst)
    last_xfer |=> out_valid)
    else $error("no verdict after final byte");

endmodule
